// ----- rtl/pixelate_mosaic_filter_unit_macros.svh -----
// Assertion macros shared by the mosaic filter RTL.
`ifndef PIXELATE_MOSAIC_FILTER_UNIT_MACROS_SVH
`define PIXELATE_MOSAIC_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/pmf_pkg.sv -----
package pmf_pkg;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int PADDR_W = 3;
	localparam int OBUF_DEPTH = 3;
	localparam int OBUF_LVL_W = $clog2(OBUF_DEPTH + 1);

	localparam logic [7:0] BLOCK_SIZE_RST = 8'd8;
	localparam logic [12:0] IMAGE_WIDTH_RST = 13'd1920;

	localparam logic REG_BLOCK_SIZE = 1'b0;
	localparam logic REG_IMAGE_WIDTH = 1'b1;

	typedef struct packed {
		logic load;
		logic store;
	} line_op_t;
endpackage

// ----- rtl/pmf_pix_in_if.sv -----
interface pmf_pix_in_if;
	logic valid;
	logic ready;
	logic [31:0] pixel_color;
	logic frame_start;

	modport source (output valid, output pixel_color, output frame_start, input ready);
	modport sink (input valid, input pixel_color, input frame_start, output ready);
endinterface

// ----- rtl/pmf_pix_out_if.sv -----
interface pmf_pix_out_if;
	logic valid;
	logic ready;
	logic [31:0] mosaic_color;

	modport source (output valid, output mosaic_color, input ready);
	modport sink (input valid, input mosaic_color, output ready);
endinterface

// ----- rtl/pmf_ram.sv -----
module pmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

// ----- rtl/pmf_ctrl.sv -----
`include "pixelate_mosaic_filter_unit_macros.svh"

module pmf_ctrl import pmf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         frame_start,
	input  logic [7:0]                   block_size,
	input  logic [12:0]                  image_width,
	output line_op_t                     op,
	output logic [$clog2(MAX_WIDTH)-1:0] addr
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CMPW = (CW + 1 > 13) ? CW + 1 : 13;

	logic [CW-1:0]   col_cnt_q, col_cnt_e, blk_col_q, blk_col_e;
	logic [7:0]      col_ph_q, col_ph_e, row_ph_q, row_ph_e, bs_eff;
	logic [8:0]      col_ph_inc, row_ph_inc;
	logic [CW:0]     col_cnt_inc;
	logic [CMPW-1:0] w_ext, w_lim;

	assign bs_eff = (block_size == 8'd0) ? 8'd1 : block_size;
	assign w_ext = CMPW'(image_width);

	always_comb begin
		if (image_width == 13'd0) begin
			w_lim = CMPW'(1);
		end else if (w_ext > CMPW'(MAX_WIDTH)) begin
			w_lim = CMPW'(MAX_WIDTH);
		end else begin
			w_lim = w_ext;
		end
	end

	assign col_cnt_e = frame_start ? '0 : col_cnt_q;
	assign blk_col_e = frame_start ? '0 : blk_col_q;
	assign col_ph_e = frame_start ? 8'd0 : col_ph_q;
	assign row_ph_e = frame_start ? 8'd0 : row_ph_q;

	assign op.store = (col_ph_e == 8'd0) && (row_ph_e == 8'd0);
	assign op.load = (col_ph_e == 8'd0) && (row_ph_e != 8'd0);
	assign addr = blk_col_e;

	assign col_cnt_inc = {1'b0, col_cnt_e} + (CW+1)'(1);
	assign col_ph_inc = {1'b0, col_ph_e} + 9'd1;
	assign row_ph_inc = {1'b0, row_ph_e} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			blk_col_q <= '0;
			col_ph_q <= 8'd0;
			row_ph_q <= 8'd0;
		end else if (accept) begin
			if (CMPW'(col_cnt_inc) >= w_lim) begin
				col_cnt_q <= '0;
				blk_col_q <= '0;
				col_ph_q <= 8'd0;
				row_ph_q <= (row_ph_inc >= {1'b0, bs_eff}) ? 8'd0 : row_ph_inc[7:0];
			end else begin
				col_cnt_q <= col_cnt_inc[CW-1:0];
				if (col_ph_inc >= {1'b0, bs_eff}) begin
					col_ph_q <= 8'd0;
					blk_col_q <= blk_col_e + CW'(1);
				end else begin
					col_ph_q <= col_ph_inc[7:0];
					blk_col_q <= blk_col_e;
				end
				row_ph_q <= row_ph_e;
			end
		end
	end

	`PMF_ASSERT_IMP(a_op_excl, clk, arst_n, 1'b1, !(op.load && op.store), "load and store together")
	`PMF_ASSERT_IMP(a_col_le, clk, arst_n, 1'b1, blk_col_q <= col_cnt_q, "block column ahead of column")
endmodule

// ----- rtl/pmf_obuf.sv -----
`include "pixelate_mosaic_filter_unit_macros.svh"

module pmf_obuf import pmf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [31:0]           push_data,
	output logic [OBUF_LVL_W-1:0] level,
	pmf_pix_out_if.source         pix_out
);
	localparam int PW = $clog2(OBUF_DEPTH);

	logic [31:0]           buf_q [OBUF_DEPTH];
	logic [PW-1:0]         wptr_q, rptr_q;
	logic [OBUF_LVL_W-1:0] cnt_q;
	logic                  pop;

	assign pop = pix_out.valid && pix_out.ready;
	assign pix_out.valid = (cnt_q != '0);
	assign pix_out.mosaic_color = buf_q[rptr_q];
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(OBUF_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(OBUF_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OBUF_LVL_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OBUF_LVL_W'(1);
			end
		end
	end

	`PMF_ASSERT_IMP(a_no_ovf, clk, arst_n, push, (cnt_q != OBUF_LVL_W'(OBUF_DEPTH)) || pop, "output buffer overflow")
endmodule

// ----- rtl/pixelate_mosaic_filter_unit.sv -----
// Pixelate (mosaic) filter for a raster-order stream of 32-bit ARGB pixels.
// pix_in carries pixel_color and frame_start (set on a frame's first beat);
// pix_out carries mosaic_color, one beat per input beat, in order.
// Each pixel takes the colour of the top-left pixel of its square block.
// The APB port holds block_size (0x0) and image_width (0x4); write them
// only while the stream is idle.
// Throughput: one pixel per clock while pix_out is ready. An accepted beat
// is registered in stage one and then written to the output buffer, from
// which it is shown on pix_out. The line store is one RAM of MAX_WIDTH
// colours with one port: the first row of each block row writes one entry
// per block column, later rows read it back in the cycle before its use.
// Reset puts the counters at the top-left corner and clears the held
// colour; the line store is not cleared, as every entry is written before
// it is read. A stalled receiver fills a three-beat output buffer; pix_in.ready
// drops once the buffered beats and the beat in stage one reach three, and
// rises again as beats drain; nothing is lost.
`include "pixelate_mosaic_filter_unit_macros.svh"

module pixelate_mosaic_filter_unit import pmf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	pmf_pix_in_if.sink         pix_in,
	pmf_pix_out_if.source      pix_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam int CW = $clog2(MAX_WIDTH);

	logic [7:0]            block_size_q;
	logic [12:0]           image_width_q;
	logic                  accept, s1_v_q, push;
	line_op_t              op, op_s1;
	logic [CW-1:0]         addr;
	logic [31:0]           pix_s1, rdata, held_q, held_n;
	logic [OBUF_LVL_W-1:0] level;
	logic [OBUF_LVL_W:0]   busy;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RST;
			image_width_q <= IMAGE_WIDTH_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_BLOCK_SIZE: block_size_q <= pwdata[7:0];
				REG_IMAGE_WIDTH: image_width_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BLOCK_SIZE: prdata = {24'd0, block_size_q};
			REG_IMAGE_WIDTH: prdata = {19'd0, image_width_q};
			default: prdata = 32'd0;
		endcase
	end

	assign busy = {1'b0, level} + (OBUF_LVL_W+1)'(s1_v_q);
	assign pix_in.ready = (busy < (OBUF_LVL_W+1)'(OBUF_DEPTH));
	assign accept = pix_in.valid && pix_in.ready;

	pmf_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.frame_start(pix_in.frame_start),
		.block_size(block_size_q),
		.image_width(image_width_q),
		.op(op),
		.addr(addr)
	);

	pmf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line (
		.clk(clk),
		.we(accept && op.store),
		.re(accept && op.load),
		.addr(addr),
		.wdata(pix_in.pixel_color),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
			pix_s1 <= pix_in.pixel_color;
		end
	end

	always_comb begin
		if (op_s1.store) begin
			held_n = pix_s1;
		end else if (op_s1.load) begin
			held_n = rdata;
		end else begin
			held_n = held_q;
		end
	end

	assign push = s1_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			held_q <= 32'd0;
		end else begin
			s1_v_q <= accept;
			if (s1_v_q) begin
				held_q <= held_n;
			end
		end
	end

	pmf_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(held_n),
		.level(level),
		.pix_out(pix_out)
	);

	`PMF_ASSERT_NXT(a_acc_s1, clk, arst_n, accept, s1_v_q, "accepted beat missing from stage one")
	`PMF_ASSERT_NXT(a_store_held, clk, arst_n, s1_v_q && op_s1.store, held_q == $past(pix_s1), "held colour not taken from stored pixel")
endmodule
